FILE: design/frsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package frsa_pkg;

    // Sizing of the ring and the frame queue.
    localparam int MAX_SLOTS     = 65536;
    localparam int FRAME_RECORDS = 8;
    localparam int PTR_W         = (FRAME_RECORDS > 1) ? $clog2(FRAME_RECORDS) : 1;
    localparam int FILL_W        = $clog2(FRAME_RECORDS + 1);

    // Fixed field widths.
    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 17;
    localparam int IDX_W    = 16;
    localparam int FENCE_W  = 64;
    localparam int STATUS_W = 3;
    localparam int FRAMES_W = 4;
    localparam int DIVD_W   = SLOT_W + 1;

    // Stream payload layout.
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 80;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_CAPACITY = 1'b0;
    localparam logic REG_RESERVED = 1'b1;
    localparam logic [SLOT_W-1:0] CAPACITY_RESET = SLOT_W'(1024);
    localparam logic [IDX_W-1:0]  RESERVED_RESET = IDX_W'(16);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_BEGIN = 2'd1,
        CMD_END   = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_ZERO_COUNT    = 3'd1,
        ST_NO_SPACE      = 3'd2,
        ST_NO_SPACE_WRAP = 3'd3,
        ST_REC_OVERFLOW  = 3'd4,
        ST_EMPTY_FRAME   = 3'd5
    } status_code_t;

    typedef struct packed {
        logic                  we;
        logic                  idx;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic alloc_check;
        logic wrap;
        logic recheck;
        logic grant;
        logic ret_read;
        logic mod_start;
        logic ret_apply;
        logic frame_clr;
        logic end_frame;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zero_count;
        logic no_space;
        logic need_wrap;
        logic fill_empty;
        logic fence_stop;
        logic ring_empty;
        logic mod_done;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/frsa_mod.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder unit, one dividend bit per cycle.
module frsa_mod (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [frsa_pkg::DIVD_W-1:0]   dividend,
    input  wire logic [frsa_pkg::SLOT_W-1:0]   divisor,
    output logic                               done,
    output logic [frsa_pkg::SLOT_W-1:0]        remainder
);
    import frsa_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [DIVD_W-1:0] divd_reg, divd_next;
    logic [SLOT_W-1:0] rem_reg,  rem_next;
    logic [DIVD_W-1:0] trial;

    always_comb begin
        trial     = {rem_reg, divd_reg[DIVD_W-1]};
        cnt_next  = cnt_reg;
        divd_next = divd_reg;
        rem_next  = rem_reg;
        if (start) begin
            cnt_next  = CNT_W'(DIVD_W);
            divd_next = dividend;
            rem_next  = '0;
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - 1'b1;
            divd_next = {divd_reg[DIVD_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                rem_next = SLOT_W'(trial - {1'b0, divisor});
            end else begin
                rem_next = trial[SLOT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        divd_reg <= divd_next;
        rem_reg  <= rem_next;
    end

    assign done      = (cnt_reg == '0);
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: design/frsa_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module frsa_dp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire frsa_pkg::dp_cmd_t               cmd,
    output frsa_pkg::dp_stat_t                   stat,
    input  wire frsa_pkg::cfg_wr_t               cfg,
    input  wire logic [frsa_pkg::SLOT_W-1:0]     in_count,
    input  wire logic [frsa_pkg::FENCE_W-1:0]    in_fence,
    output logic [frsa_pkg::STATUS_W-1:0]        out_status,
    output logic [frsa_pkg::IDX_W-1:0]           out_heap,
    output logic [frsa_pkg::SLOT_W-1:0]          out_head,
    output logic [frsa_pkg::IDX_W-1:0]           out_tail,
    output logic [frsa_pkg::SLOT_W-1:0]          out_used,
    output logic [frsa_pkg::FRAMES_W-1:0]        out_retired,
    output logic [frsa_pkg::FRAMES_W-1:0]        out_pending,
    output logic [frsa_pkg::SLOT_W-1:0]          cfg_capacity,
    output logic [frsa_pkg::IDX_W-1:0]           cfg_reserved
);
    import frsa_pkg::*;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(FRAME_RECORDS - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // Control state.
    logic [SLOT_W-1:0] capacity_reg,  capacity_next;
    logic [IDX_W-1:0]  reserved_reg,  reserved_next;
    logic [SLOT_W-1:0] cap_eff_reg,   cap_eff_next;
    logic [SLOT_W-1:0] ring_len_reg,  ring_len_next;
    logic [SLOT_W-1:0] head_reg,      head_next;
    logic [IDX_W-1:0]  tail_reg,      tail_next;
    logic [SLOT_W-1:0] used_reg,      used_next;
    logic [SLOT_W-1:0] fslots_reg,    fslots_next;
    logic [PTR_W-1:0]  wptr_reg,      wptr_next;
    logic [PTR_W-1:0]  rptr_reg,      rptr_next;
    logic [FILL_W-1:0] fill_reg,      fill_next;

    // Payload.
    logic [SLOT_W-1:0]   count_reg,   count_next;
    logic [FENCE_W-1:0]  fence_reg,   fence_next;
    status_code_t        status_reg,  status_next;
    logic [IDX_W-1:0]    heap_reg,    heap_next;
    logic [FILL_W-1:0]   retired_reg, retired_next;
    logic [IDX_W-1:0]    off_reg,     off_next;
    logic [STATUS_W-1:0] ostat_reg,   ostat_next;
    logic [IDX_W-1:0]    oheap_reg,   oheap_next;
    logic [SLOT_W-1:0]   ohead_reg,   ohead_next;
    logic [IDX_W-1:0]    otail_reg,   otail_next;
    logic [SLOT_W-1:0]   oused_reg,   oused_next;
    logic [FRAMES_W-1:0] oret_reg,    oret_next;
    logic [FRAMES_W-1:0] opend_reg,   opend_next;

    // Frame queue storage.
    logic [FENCE_W-1:0] rec_fence_mem [FRAME_RECORDS];
    logic [SLOT_W-1:0]  rec_slots_mem [FRAME_RECORDS];
    logic [FENCE_W-1:0] rec_fence_q_reg;
    logic [SLOT_W-1:0]  rec_slots_q_reg;
    logic               rec_we;

    logic [SLOT_W-1:0] cap_clamp;
    logic [SLOT_W-1:0] waste;
    logic              fill_full;
    logic [DIVD_W-1:0] mod_dividend;
    logic              mod_done;
    logic [SLOT_W-1:0] mod_rem;

    frsa_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mod_start),
        .dividend  (mod_dividend),
        .divisor   (ring_len_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb begin
        cap_clamp = (capacity_reg > SLOT_W'(MAX_SLOTS)) ? SLOT_W'(MAX_SLOTS) : capacity_reg;
        waste     = (head_reg < cap_eff_reg) ? (cap_eff_reg - head_reg) : '0;
        fill_full = (fill_reg >= FILL_W'(FRAME_RECORDS));
        mod_dividend = {2'b00, off_reg} + {1'b0, rec_slots_q_reg};

        stat.zero_count = (count_reg == '0);
        stat.no_space   = ({1'b0, used_reg} + {1'b0, count_reg}) > {1'b0, ring_len_reg};
        stat.need_wrap  = ({1'b0, head_reg} + {1'b0, count_reg}) > {1'b0, cap_eff_reg};
        stat.fill_empty = (fill_reg == '0);
        stat.fence_stop = (rec_fence_q_reg > fence_reg);
        stat.ring_empty = (ring_len_reg == '0);
        stat.mod_done   = mod_done;

        rec_we = cmd.end_frame && (fslots_reg != '0) && !fill_full;
    end

    always_comb begin
        capacity_next = capacity_reg;
        reserved_next = reserved_reg;
        cap_eff_next  = cap_clamp;
        ring_len_next = (cap_clamp > {1'b0, reserved_reg}) ?
                        (cap_clamp - {1'b0, reserved_reg}) : '0;
        head_next     = head_reg;
        tail_next     = tail_reg;
        used_next     = used_reg;
        fslots_next   = fslots_reg;
        wptr_next     = wptr_reg;
        rptr_next     = rptr_reg;
        fill_next     = fill_reg;
        count_next    = count_reg;
        fence_next    = fence_reg;
        status_next   = status_reg;
        heap_next     = heap_reg;
        retired_next  = retired_reg;
        off_next      = off_reg;
        ostat_next    = ostat_reg;
        oheap_next    = oheap_reg;
        ohead_next    = ohead_reg;
        otail_next    = otail_reg;
        oused_next    = oused_reg;
        oret_next     = oret_reg;
        opend_next    = opend_reg;

        if (cfg.we) begin
            // Any register write restarts the ring from the reserved boundary.
            if (cfg.idx == REG_CAPACITY) begin
                capacity_next = cfg.data[SLOT_W-1:0];
            end else begin
                reserved_next = cfg.data[IDX_W-1:0];
            end
            head_next   = {1'b0, reserved_next};
            tail_next   = reserved_next;
            used_next   = '0;
            fslots_next = '0;
            wptr_next   = '0;
            rptr_next   = '0;
            fill_next   = '0;
        end else begin
            if (cmd.load) begin
                count_next   = in_count;
                fence_next   = in_fence;
                status_next  = ST_OK;
                heap_next    = '0;
                retired_next = '0;
            end
            if (cmd.alloc_check) begin
                if (stat.zero_count) begin
                    status_next = ST_ZERO_COUNT;
                end else if (stat.no_space) begin
                    status_next = ST_NO_SPACE;
                end
            end
            if (cmd.wrap) begin
                // The tail end of the ring is charged to the frame and skipped.
                used_next   = used_reg + waste;
                fslots_next = fslots_reg + waste;
                head_next   = {1'b0, reserved_reg};
            end
            if (cmd.recheck && stat.no_space) begin
                status_next = ST_NO_SPACE_WRAP;
            end
            if (cmd.grant) begin
                heap_next   = head_reg[IDX_W-1:0];
                head_next   = head_reg + count_reg;
                used_next   = used_reg + count_reg;
                fslots_next = fslots_reg + count_reg;
            end
            if (cmd.ret_read) begin
                off_next = ({1'b0, tail_reg} >= {1'b0, reserved_reg}) ?
                           (tail_reg - reserved_reg) : '0;
            end
            if (cmd.ret_apply) begin
                if (!stat.ring_empty) begin
                    tail_next = reserved_reg + mod_rem[IDX_W-1:0];
                end
                used_next    = (used_reg > rec_slots_q_reg) ? (used_reg - rec_slots_q_reg) : '0;
                rptr_next    = ptr_inc(rptr_reg);
                fill_next    = fill_reg - 1'b1;
                retired_next = retired_reg + 1'b1;
            end
            if (cmd.frame_clr) begin
                fslots_next = '0;
            end
            if (cmd.end_frame) begin
                if (fslots_reg == '0) begin
                    status_next = ST_EMPTY_FRAME;
                end else if (fill_full) begin
                    status_next = ST_REC_OVERFLOW;
                end else begin
                    wptr_next = ptr_inc(wptr_reg);
                    fill_next = fill_reg + 1'b1;
                end
            end
            if (cmd.out_load) begin
                ostat_next = status_reg;
                oheap_next = heap_reg;
                ohead_next = head_reg;
                otail_next = tail_reg;
                oused_next = used_reg;
                oret_next  = FRAMES_W'(retired_reg);
                opend_next = FRAMES_W'(fill_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAPACITY_RESET;
            reserved_reg <= RESERVED_RESET;
            cap_eff_reg  <= CAPACITY_RESET;
            ring_len_reg <= CAPACITY_RESET - {1'b0, RESERVED_RESET};
            head_reg     <= {1'b0, RESERVED_RESET};
            tail_reg     <= RESERVED_RESET;
            used_reg     <= '0;
            fslots_reg   <= '0;
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            fill_reg     <= '0;
        end else begin
            capacity_reg <= capacity_next;
            reserved_reg <= reserved_next;
            cap_eff_reg  <= cap_eff_next;
            ring_len_reg <= ring_len_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            used_reg     <= used_next;
            fslots_reg   <= fslots_next;
            wptr_reg     <= wptr_next;
            rptr_reg     <= rptr_next;
            fill_reg     <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg   <= count_next;
        fence_reg   <= fence_next;
        status_reg  <= status_next;
        heap_reg    <= heap_next;
        retired_reg <= retired_next;
        off_reg     <= off_next;
        ostat_reg   <= ostat_next;
        oheap_reg   <= oheap_next;
        ohead_reg   <= ohead_next;
        otail_reg   <= otail_next;
        oused_reg   <= oused_next;
        oret_reg    <= oret_next;
        opend_reg   <= opend_next;
    end

    always_ff @(posedge aclk) begin
        if (rec_we) begin
            rec_fence_mem[wptr_reg] <= fence_reg;
            rec_slots_mem[wptr_reg] <= fslots_reg;
        end
        if (cmd.ret_read) begin
            rec_fence_q_reg <= rec_fence_mem[rptr_reg];
            rec_slots_q_reg <= rec_slots_mem[rptr_reg];
        end
    end

    assign out_status   = ostat_reg;
    assign out_heap     = oheap_reg;
    assign out_head     = ohead_reg;
    assign out_tail     = otail_reg;
    assign out_used     = oused_reg;
    assign out_retired  = oret_reg;
    assign out_pending  = opend_reg;
    assign cfg_capacity = capacity_reg;
    assign cfg_reserved = reserved_reg;

endmodule

`default_nettype wire

FILE: design/frsa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module frsa_ctrl (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [frsa_pkg::CMD_W-1:0]    s_cmd,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output frsa_pkg::dp_cmd_t                  cmd,
    input  wire frsa_pkg::dp_stat_t            stat
);
    import frsa_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_ACHK   = 12'b0000_0000_0010,
        S_AWRAP  = 12'b0000_0000_0100,
        S_ARECHK = 12'b0000_0000_1000,
        S_AGRANT = 12'b0000_0001_0000,
        S_RREAD  = 12'b0000_0010_0000,
        S_RCHECK = 12'b0000_0100_0000,
        S_RMOD   = 12'b0000_1000_0000,
        S_RAPPLY = 12'b0001_0000_0000,
        S_FCLR   = 12'b0010_0000_0000,
        S_EFRAME = 12'b0100_0000_0000,
        S_DONE   = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    case (cmd_t'(s_cmd))
                        CMD_ALLOC: state_next = S_ACHK;
                        CMD_BEGIN: state_next = S_RREAD;
                        CMD_END:   state_next = S_EFRAME;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_ACHK: begin
                cmd.alloc_check = 1'b1;
                if (stat.zero_count || stat.no_space) begin
                    state_next = S_DONE;
                end else if (stat.need_wrap) begin
                    state_next = S_AWRAP;
                end else begin
                    state_next = S_AGRANT;
                end
            end
            S_AWRAP: begin
                cmd.wrap   = 1'b1;
                state_next = S_ARECHK;
            end
            S_ARECHK: begin
                // A failure here keeps the waste and the wrapped head.
                cmd.recheck = 1'b1;
                state_next  = stat.no_space ? S_DONE : S_AGRANT;
            end
            S_AGRANT: begin
                cmd.grant  = 1'b1;
                state_next = S_DONE;
            end
            S_RREAD: begin
                if (stat.fill_empty) begin
                    state_next = S_FCLR;
                end else begin
                    cmd.ret_read = 1'b1;
                    state_next   = S_RCHECK;
                end
            end
            S_RCHECK: begin
                if (stat.fence_stop) begin
                    state_next = S_FCLR;
                end else if (stat.ring_empty) begin
                    state_next = S_RAPPLY;
                end else begin
                    cmd.mod_start = 1'b1;
                    state_next    = S_RMOD;
                end
            end
            S_RMOD: begin
                if (stat.mod_done) begin
                    state_next = S_RAPPLY;
                end
            end
            S_RAPPLY: begin
                cmd.ret_apply = 1'b1;
                state_next    = S_RREAD;
            end
            S_FCLR: begin
                cmd.frame_clr = 1'b1;
                state_next    = S_DONE;
            end
            S_EFRAME: begin
                cmd.end_frame = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

FILE: design/fenced_ring_slot_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Ports                              Contents
// input    in   s_tvalid s_tready s_tdata s_tuser  cmd; count, fence
// result   out  m_tvalid m_tready m_tdata m_tuser  status; indexes and counters
// config   in   psel penable pwrite paddr pwdata   capacity at 0x0, reserved at 0x4
//
// One item at a time. From acceptance to the result register: allocate runs a check,
// an optional wrap and recheck and a grant, end frame its end-frame step, an unused
// code goes straight to the result, and begin frame a read and a check per record,
// each retired record's tail advance waiting on an 18-step bit-serial remainder unit.
// The next item can be accepted in the cycle after the result register loads.
// Reset is synchronous and active low; a configuration write resets the pointers
// and empties the frame queue. A finished item waits in the output register
// while the next item is accepted; the next result waits until that one is taken.
module fenced_ring_slot_allocator (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // count [16:0], fence [80:17], zero fill [87:81]
    input  wire logic [frsa_pkg::S_TDATA_W-1:0]    s_tdata,
    // cmd [1:0]
    input  wire logic [frsa_pkg::CMD_W-1:0]        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // heap_index [15:0], head_index [32:16], tail_index [48:33], used_slots [65:49],
    // retired_frames [69:66], queued_frames [73:70], zero fill [79:74]
    output logic [frsa_pkg::M_TDATA_W-1:0]         m_tdata,
    // status [2:0]
    output logic [frsa_pkg::STATUS_W-1:0]          m_tuser,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [frsa_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [frsa_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [frsa_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                   pready
);
    import frsa_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    cfg_wr_t  cfg;

    logic [STATUS_W-1:0] out_status;
    logic [IDX_W-1:0]    out_heap;
    logic [SLOT_W-1:0]   out_head;
    logic [IDX_W-1:0]    out_tail;
    logic [SLOT_W-1:0]   out_used;
    logic [FRAMES_W-1:0] out_retired;
    logic [FRAMES_W-1:0] out_pending;
    logic [SLOT_W-1:0]   cfg_capacity;
    logic [IDX_W-1:0]    cfg_reserved;

    assign pready   = 1'b1;
    assign cfg.we   = psel && penable && pwrite && pready;
    assign cfg.idx  = paddr[2];
    assign cfg.data = pwdata;

    always_comb begin
        if (paddr[1:0] != 2'b00) begin
            prdata = '0;
        end else if (paddr[2] == REG_RESERVED) begin
            prdata = CFG_DATA_W'(cfg_reserved);
        end else begin
            prdata = CFG_DATA_W'(cfg_capacity);
        end
    end

    frsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_cmd    (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    frsa_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .cfg          (cfg),
        .in_count     (s_tdata[SLOT_W-1:0]),
        .in_fence     (s_tdata[SLOT_W+FENCE_W-1:SLOT_W]),
        .out_status   (out_status),
        .out_heap     (out_heap),
        .out_head     (out_head),
        .out_tail     (out_tail),
        .out_used     (out_used),
        .out_retired  (out_retired),
        .out_pending  (out_pending),
        .cfg_capacity (cfg_capacity),
        .cfg_reserved (cfg_reserved)
    );

    assign m_tuser = out_status;
    assign m_tdata = {6'b0, out_pending, out_retired, out_used, out_tail, out_head, out_heap};

endmodule

`default_nettype wire

FILE: design/frsa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module frsa_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [frsa_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic [frsa_pkg::STATUS_W-1:0]     m_tuser
);
    import frsa_pkg::*;

    logic [FRAMES_W:0] frames_sum;
    assign frames_sum = {1'b0, m_tdata[69:66]} + {1'b0, m_tdata[73:70]};

    // A waiting result keeps its contents until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_no_valid_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Only a granted allocate reports a heap index.
    a_heap_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[15:0] == '0))
        else $error("heap index set on a failed command");

    // Retired plus pending records fit the queue depth; the status is valid.
    a_frames: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (frames_sum <= (FRAMES_W+1)'(FRAME_RECORDS))
                     && (m_tuser <= STATUS_W'(ST_EMPTY_FRAME)))
        else $error("frame counts or status out of range");

endmodule

bind fenced_ring_slot_allocator frsa_checker u_frsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: verif/fenced_ring_slot_allocator_tb.sv
`timescale 1ns / 1ps

module fenced_ring_slot_allocator_tb;
    import frsa_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] RESERVED_ADDR = {REG_RESERVED, 2'b00};
    localparam logic [FENCE_W-1:0]    FENCE_MAX     = '1;
    localparam int                    LONG_HOLD     = 300;

    typedef struct packed {
        cmd_t                cmd;
        logic [SLOT_W-1:0]   count;
        logic [FENCE_W-1:0]  fence;
    } command_t;

    typedef struct packed {
        status_code_t        status;
        logic [IDX_W-1:0]    heap_index;
        logic [SLOT_W-1:0]   head_index;
        logic [IDX_W-1:0]    tail_index;
        logic [SLOT_W-1:0]   used_slots;
        logic [FRAMES_W-1:0] retired;
        logic [FRAMES_W-1:0] pending;
    } slot_result_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata  = '0;
    logic [CMD_W-1:0]        s_tuser  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic [STATUS_W-1:0]     m_tuser;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr    = '0;
    logic [CFG_DATA_W-1:0]   pwdata   = '0;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    // Allocator state as the testbench expects it to be.
    logic [SLOT_W-1:0]       cfg_capacity;
    logic [IDX_W-1:0]        cfg_reserved;
    logic [SLOT_W-1:0]       ring_head;
    logic [IDX_W-1:0]        ring_tail;
    logic [SLOT_W-1:0]       slots_used;
    logic [SLOT_W-1:0]       frame_fill;
    logic [FENCE_W-1:0]      rec_fence [FRAME_RECORDS];
    logic [SLOT_W-1:0]       rec_slots [FRAME_RECORDS];
    logic [PTR_W-1:0]        rec_wr, rec_rd;
    int unsigned             rec_count;

    command_t                command_queue[$];
    slot_result_t            expected_results[$];
    logic [FENCE_W-1:0]      next_fence;

    bit                      tx_idle_on, rx_idle_on;
    int                      tx_gap, rx_wait;
    int                      items_queued, commands_sent, results_seen;
    int                      mismatches, settings_applied, holds_done;
    int                      hold_at = 200;
    int                      status_seen [6];

    fenced_ring_slot_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int unsigned eff_capacity();
        return (cfg_capacity > SLOT_W'(MAX_SLOTS)) ? 32'(MAX_SLOTS) : 32'(cfg_capacity);
    endfunction

    function automatic int unsigned ring_length();
        int unsigned cap;
        cap = eff_capacity();
        return (cap > 32'(cfg_reserved)) ? cap - 32'(cfg_reserved) : 0;
    endfunction

    function automatic logic [PTR_W-1:0] rec_next(logic [PTR_W-1:0] p);
        return (p == PTR_W'(FRAME_RECORDS - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic void clear_ring_state();
        ring_head  = {1'b0, cfg_reserved};
        ring_tail  = cfg_reserved;
        slots_used = '0;
        frame_fill = '0;
        rec_wr     = '0;
        rec_rd     = '0;
        rec_count  = 0;
    endfunction

    function automatic slot_result_t predict_command(cmd_t cmd, logic [SLOT_W-1:0] count,
                                                     logic [FENCE_W-1:0] fence);
        slot_result_t res;
        int unsigned  cap, dyn, waste, n, off;
        bit           fail, stop;
        res        = '0;
        res.status = ST_OK;
        cap = eff_capacity();
        dyn = ring_length();
        case (cmd)
            CMD_ALLOC: begin
                if (count == '0) begin
                    res.status = ST_ZERO_COUNT;
                end else if (32'(slots_used) + 32'(count) > dyn) begin
                    res.status = ST_NO_SPACE;
                end else begin
                    fail = 1'b0;
                    if (32'(ring_head) + 32'(count) > cap) begin
                        // The tail end of the ring is wasted and stays charged even if
                        // the request still does not fit after wrapping.
                        waste      = (32'(ring_head) < cap) ? cap - 32'(ring_head) : 0;
                        slots_used = SLOT_W'(32'(slots_used) + waste);
                        frame_fill = SLOT_W'(32'(frame_fill) + waste);
                        ring_head  = {1'b0, cfg_reserved};
                        if (32'(slots_used) + 32'(count) > dyn) begin
                            res.status = ST_NO_SPACE_WRAP;
                            fail       = 1'b1;
                        end
                    end
                    if (!fail) begin
                        res.heap_index = ring_head[IDX_W-1:0];
                        ring_head      = ring_head + count;
                        slots_used     = slots_used + count;
                        frame_fill     = frame_fill + count;
                    end
                end
            end
            CMD_BEGIN: begin
                stop = 1'b0;
                while (!stop && rec_count > 0 && res.retired < FRAMES_W'(FRAME_RECORDS)) begin
                    if (rec_fence[rec_rd] > fence) begin
                        stop = 1'b1;
                    end else begin
                        n = 32'(rec_slots[rec_rd]);
                        if (dyn != 0) begin
                            off       = (ring_tail >= cfg_reserved) ?
                                        32'(ring_tail - cfg_reserved) : 0;
                            ring_tail = cfg_reserved + IDX_W'((off + n) % dyn);
                        end
                        slots_used  = (32'(slots_used) > n) ?
                                      SLOT_W'(32'(slots_used) - n) : '0;
                        rec_rd      = rec_next(rec_rd);
                        rec_count   = rec_count - 1;
                        res.retired = res.retired + 1'b1;
                    end
                end
                frame_fill = '0;
            end
            CMD_END: begin
                if (frame_fill == '0) begin
                    res.status = ST_EMPTY_FRAME;
                end else if (rec_count >= FRAME_RECORDS) begin
                    res.status = ST_REC_OVERFLOW;
                end else begin
                    rec_fence[rec_wr] = fence;
                    rec_slots[rec_wr] = frame_fill;
                    rec_wr            = rec_next(rec_wr);
                    rec_count         = rec_count + 1;
                end
            end
            default: begin
            end
        endcase
        res.head_index = ring_head;
        res.tail_index = ring_tail;
        res.used_slots = slots_used;
        res.pending    = FRAMES_W'(rec_count);
        return res;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Random bits above the register's width, which the block must drop.
    function automatic logic [CFG_DATA_W-1:0] with_noise(int unsigned keep, int unsigned v);
        return ($urandom() << keep) | v;
    endfunction

    function automatic logic [SLOT_W-1:0] pick_count();
        int unsigned len, sel;
        len = ring_length();
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return SLOT_W'($urandom());
        if (sel == 2)
            return SLOT_W'(len);
        if (sel < 6)
            return SLOT_W'($urandom_range(1, (len > 1) ? len : 1));
        return SLOT_W'($urandom_range(1, (len >= 32) ? len / 16 : 2));
    endfunction

    function automatic logic [FENCE_W-1:0] completed_fence();
        int unsigned sel;
        sel = $urandom_range(0, 15);
        if (sel == 0)
            return FENCE_MAX;
        if (sel == 1)
            return '0;
        if (sel == 2)
            return {$urandom(), $urandom()};
        return next_fence - FENCE_W'($urandom_range(0, 2));
    endfunction

    task automatic push_item(cmd_t c, logic [SLOT_W-1:0] cnt, logic [FENCE_W-1:0] f);
        command_t item;
        item.cmd   = c;
        item.count = cnt;
        item.fence = f;
        command_queue.push_back(item);
        if (c != CMD_NOP)
            items_queued++;
    endtask

    // A frame is a few allocates, an end with a fresh fence and a begin that
    // retires what has completed. Some frames drop the end or the begin.
    task automatic push_frame();
        int unsigned k;
        k = $urandom_range(0, 4);
        repeat (k) push_item(CMD_ALLOC, pick_count(), {$urandom(), $urandom()});
        if ($urandom_range(0, 9) != 0) begin
            next_fence = next_fence + 1'b1;
            push_item(CMD_END, SLOT_W'($urandom()), next_fence);
        end
        if ($urandom_range(0, 6) != 0)
            push_item(CMD_BEGIN, SLOT_W'($urandom()), completed_fence());
    endtask

    task automatic wait_drained();
        while (command_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic run_phase(int n, bit tx_on, bit rx_on);
        int start, split, half;
        tx_idle_on = tx_on;
        rx_idle_on = rx_on;
        next_fence = ($urandom_range(0, 2) == 0) ? {$urandom(), $urandom()} : '0;
        start = items_queued;
        split = $urandom_range(n / 4, 3 * n / 4);
        for (half = 0; half < 2; half++) begin
            while (items_queued - start < ((half == 0) ? split : n)) begin
                if ($urandom_range(0, 9) == 0)
                    push_item(cmd_t'($urandom_range(0, 3)), SLOT_W'($urandom()),
                              {$urandom(), $urandom()});
                else
                    push_frame();
            end
            // The sender pauses here until every result is back.
            wait_drained();
        end
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
        repeat (8) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == CAPACITY_ADDR)
            cfg_capacity = value[SLOT_W-1:0];
        else if (addr == RESERVED_ADDR)
            cfg_reserved = value[IDX_W-1:0];
        clear_ring_state();
        settings_applied++;
        @(negedge aclk);
    endtask

    task automatic write_both(int unsigned cap, int unsigned rsv);
        write_reg(CAPACITY_ADDR, with_noise(SLOT_W, cap));
        write_reg(RESERVED_ADDR, with_noise(IDX_W, rsv));
    endtask

    always @(posedge aclk) begin : driver
        command_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_command(cmd_t'(s_tuser),
                                                           s_tdata[SLOT_W-1:0],
                                                           s_tdata[SLOT_W+FENCE_W-1:SLOT_W]));
                commands_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap = tx_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (command_queue.size() > 0) begin
                    item = command_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, item.fence, item.count};
                    s_tuser  <= item.cmd;
                    tx_gap = tx_idle_on ? $urandom_range(0, 16) : 0;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : monitor
        slot_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result mismatch, expected none, actual status %0d data %h",
                             $time, m_tuser, m_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 64'(want.status), 64'(m_tuser));
                    check_field("heap_index", 64'(want.heap_index), 64'(m_tdata[15:0]));
                    check_field("head_index", 64'(want.head_index), 64'(m_tdata[32:16]));
                    check_field("tail_index", 64'(want.tail_index), 64'(m_tdata[48:33]));
                    check_field("used_slots", 64'(want.used_slots), 64'(m_tdata[65:49]));
                    check_field("retired_frames", 64'(want.retired), 64'(m_tdata[69:66]));
                    check_field("queued_frames", 64'(want.pending), 64'(m_tdata[73:70]));
                    status_seen[want.status]++;
                end
                results_seen++;
                // Now and then stop taking results for a long while so the block
                // backs up and holds off the sender, which keeps offering items.
                if (holds_done < 2 && results_seen >= hold_at && command_queue.size() > 20) begin
                    rx_wait = LONG_HOLD;
                    holds_done++;
                    hold_at = hold_at + 500;
                end else begin
                    rx_wait = rx_idle_on ? $urandom_range(0, 16) : 0;
                end
            end else if (rx_wait > 0) begin
                rx_wait = rx_wait - 1;
            end
            m_tready <= (rx_wait == 0);
        end
    end

    initial begin : stimulus
        int i;
        cfg_capacity = CAPACITY_RESET;
        cfg_reserved = RESERVED_RESET;
        clear_ring_state();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part on the reset geometry of 1008 ring slots.
        push_item(CMD_NOP, '1, FENCE_MAX);
        push_item(CMD_ALLOC, '0, '0);
        push_item(CMD_END, '0, '0);                      // nothing allocated in this frame
        push_item(CMD_ALLOC, '1, FENCE_MAX);             // far more than the ring holds
        push_item(CMD_ALLOC, SLOT_W'(1000), '0);
        push_item(CMD_END, '0, FENCE_W'(10));
        push_item(CMD_BEGIN, '0, FENCE_W'(9));           // fence not reached yet
        push_item(CMD_BEGIN, '1, FENCE_W'(10));
        push_item(CMD_ALLOC, SLOT_W'(5), '0);
        push_item(CMD_ALLOC, SLOT_W'(4), '0);            // wraps and wastes three slots
        push_item(CMD_ALLOC, SLOT_W'(996), '0);          // ring now full
        push_item(CMD_END, '0, FENCE_W'(20));
        push_item(CMD_END, '0, FENCE_W'(21));            // same frame queued a second time
        push_item(CMD_BEGIN, '0, FENCE_MAX);             // second retirement saturates at zero
        push_item(CMD_ALLOC, SLOT_W'(1), '0);
        push_item(CMD_END, '0, FENCE_W'(30));
        push_item(CMD_BEGIN, '0, '0);
        push_item(CMD_ALLOC, SLOT_W'(1007), '0);         // fits before the wrap, fails after it
        for (i = 0; i < 8; i++)
            push_item(CMD_END, '0, FENCE_W'(31 + i));    // the last one overflows the queue
        push_item(CMD_BEGIN, '0, FENCE_MAX);             // retires the whole queue
        wait_drained();
        run_phase(150, 1'b1, 1'b1);

        write_both('1, 0);                     // capacity clamps to the largest ring
        run_phase(170, 1'b0, 1'b0);
        write_both(2, 0);
        run_phase(150, 1'b1, 1'b0);
        write_both(40, 40);                    // reserved equals capacity
        run_phase(100, 1'b0, 1'b1);
        write_both(100, 65535);
        run_phase(80, 1'b1, 1'b1);
        write_both(65536, 65535);              // single-slot ring
        run_phase(120, 1'b1, 1'b1);
        write_both(64, 8);
        run_phase(200, 1'b0, 1'b1);
        i = $urandom_range(2, 65536);
        write_both(i, $urandom_range(0, i - 1));
        run_phase(200, 1'b1, 1'b1);
        write_reg(CAPACITY_ADDR, with_noise(SLOT_W, 300));
        run_phase(150, 1'b1, 1'b1);

        repeat (200) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     expected_results.size());
        end
        $display("Sent %0d commands under %0d register writes, %0d results compared.",
                 commands_sent, settings_applied, results_seen);
        $display("Status mix: ok %0d, zero %0d, full %0d, full after wrap %0d, %s %0d, %s %0d",
                 status_seen[ST_OK], status_seen[ST_ZERO_COUNT], status_seen[ST_NO_SPACE],
                 status_seen[ST_NO_SPACE_WRAP], "queue overflow",
                 status_seen[ST_REC_OVERFLOW], "empty frame", status_seen[ST_EMPTY_FRAME]);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
